// File: src/tirr_pkg.sv
// shared types and constants for the timestamped input record/replay log
// no dependencies; imported by the interfaces and every module

package tirr_pkg;

  localparam int unsigned TickW  = 48;
  localparam int unsigned BtnW   = 8;
  localparam int unsigned CountW = 13;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_PLAY   = 2'd1,
    OP_TRUNC  = 2'd2,
    OP_FORCE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_ORDER = 2'd2
  } status_e;

  typedef struct packed {
    logic [TickW-1:0] tick;
    logic [BtnW-1:0]  buttons;
  } entry_t;

endpackage

// File: src/tirr_if.sv
// valid/ready channel interfaces for request and result items
// depends on tirr_pkg

interface tirr_in_if import tirr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [BtnW-1:0]   button_set;
  logic [TickW-1:0]  tick_time;

  modport source (output valid, opcode, button_set, tick_time, input ready);
  modport sink   (input valid, opcode, button_set, tick_time, output ready);
endinterface

interface tirr_out_if import tirr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BtnW-1:0]   buttons_out;
  logic [1:0]        status;
  logic              appended;
  logic [CountW-1:0] entry_count;

  modport source (output valid, buttons_out, status, appended, entry_count, input ready);
  modport sink   (input valid, buttons_out, status, appended, entry_count, output ready);
endinterface

// File: src/tirr_log_ram.sv
// log memory: one write port, one read port with registered read data
// depends on tirr_pkg for the entry layout

module tirr_log_ram import tirr_pkg::*; #(
  parameter  int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/timestamped_input_record_replay.sv
// Timestamped input record/replay log: keeps a tick-sorted list of button sets.
// in_i carries one request item: opcode (record if changed, playback query,
// truncate at tick, forced append), a button set and a 48-bit tick. out_o
// returns one result item per request: the buttons in effect at that tick
// after the operation, a status code, an appended flag and the entry count.
// Both channels move an item when valid and ready are high at a clock edge.
// One request is worked at a time. An append first checks and writes the log,
// then every request runs a binary search over the log memory of at most
// ceil(log2(count)) probes, each of which issues the address and then uses
// the registered read data. The next request is taken once the result is
// presented.
// The result sits in an output register; a new request is accepted while it
// waits, and the next result is held back until out_o takes the previous one.
// Reset (rst_ni low, asynchronous) leaves one entry of no buttons at tick 0,
// entry 0 being implied by logic, never stored. No clearing pass is needed.
// depends on tirr_pkg, tirr_if and tirr_log_ram

module timestamped_input_record_replay import tirr_pkg::*; #(
  parameter int unsigned LOG_DEPTH = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tirr_in_if.sink    in_i,
  tirr_out_if.source out_o
);

  localparam int unsigned AW = $clog2(LOG_DEPTH);
  localparam int unsigned CW = $clog2(LOG_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_APPEND = 5'b00010,
    S_SEARCH = 5'b00100,
    S_WAIT   = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [BtnW-1:0]   btn_q, btn_d;
  logic [TickW-1:0]  t_q, t_d;
  logic [AW-1:0]     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  entry_t            lo_ent_q, lo_ent_d;
  status_e           status_q, status_d;
  logic              app_q, app_d;

  logic [CW-1:0]     count_q, count_d;
  logic [BtnW-1:0]   last_rec_q, last_rec_d;
  logic [TickW-1:0]  last_tick_q, last_tick_d;
  logic [AW-1:0]     cursor_q, cursor_d;

  logic              out_valid_q, out_valid_d;
  logic [BtnW-1:0]   out_btn_q, out_btn_d;
  status_e           out_stat_q, out_stat_d;
  logic              out_app_q, out_app_d;
  logic [CountW-1:0] out_cnt_q, out_cnt_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;

  logic              in_fire, out_free;
  logic [AW:0]       span;
  logic [AW-1:0]     mid;
  logic [CW-1:0]     count_m1, cnt_next;
  logic [CW+CountW-1:0] cnt_ext;

  tirr_log_ram #(
    .Depth (LOG_DEPTH)
  ) u_log_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_free   = ~out_valid_q | out_o.ready;

  // upper midpoint, so a probe never touches entry 0
  assign span     = {1'b0, hi_q} - {1'b0, lo_q} + {{AW{1'b0}}, 1'b1};
  assign mid      = lo_q + span[AW:1];
  assign count_m1 = count_q - CW'(1);

  // entry count after this item commits
  assign cnt_next = (op_q == OP_TRUNC) ? (CW'(lo_q) + CW'(1)) : count_q;
  assign cnt_ext  = {{CountW{1'b0}}, cnt_next};

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    btn_d       = btn_q;
    t_d         = t_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    lo_ent_d    = lo_ent_q;
    status_d    = status_q;
    app_d       = app_q;
    count_d     = count_q;
    last_rec_d  = last_rec_q;
    last_tick_d = last_tick_q;
    cursor_d    = cursor_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_btn_d   = out_btn_q;
    out_stat_d  = out_stat_q;
    out_app_d   = out_app_q;
    out_cnt_d   = out_cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[AW-1:0];
    ram_wdata   = '{tick: t_q, buttons: btn_q};
    ram_re      = 1'b0;
    ram_raddr   = mid;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d     = op_e'(in_i.opcode);
          btn_d    = in_i.button_set;
          t_d      = in_i.tick_time;
          lo_d     = '0;
          hi_d     = count_m1[AW-1:0];
          lo_ent_d = '0;
          status_d = STAT_OK;
          app_d    = 1'b0;
          if (op_e'(in_i.opcode) == OP_RECORD || op_e'(in_i.opcode) == OP_FORCE) begin
            state_d = S_APPEND;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_APPEND: begin
        state_d = S_SEARCH;
        if (op_q == OP_FORCE || btn_q != last_rec_q) begin
          if (count_q == CW'(LOG_DEPTH)) begin
            status_d = STAT_FULL;
          end else if (t_q < last_tick_q) begin
            status_d = STAT_ORDER;
          end else begin
            ram_we      = 1'b1;
            count_d     = count_q + CW'(1);
            last_rec_d  = btn_q;
            last_tick_d = t_q;
            app_d       = 1'b1;
            // new entry is the last one
            hi_d        = count_q[AW-1:0];
          end
        end
      end
      S_SEARCH: begin
        if (lo_q < hi_q) begin
          ram_re  = 1'b1;
          mid_d   = mid;
          state_d = S_WAIT;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_WAIT: begin
        state_d = S_SEARCH;
        if (ram_rdata.tick <= t_q) begin
          lo_d     = mid_q;
          lo_ent_d = ram_rdata;
        end else begin
          hi_d = mid_q - AW'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          out_btn_d   = lo_ent_q.buttons;
          out_stat_d  = status_q;
          out_app_d   = app_q;
          out_cnt_d   = cnt_ext[CountW-1:0];
          case (op_q)
            OP_PLAY: begin
              cursor_d = lo_q;
            end
            OP_TRUNC: begin
              count_d     = cnt_next;
              last_rec_d  = lo_ent_q.buttons;
              last_tick_d = lo_ent_q.tick;
              if (cursor_q > lo_q) begin
                cursor_d = lo_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CW'(1);
      last_rec_q  <= '0;
      last_tick_q <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      last_rec_q  <= last_rec_d;
      last_tick_q <= last_tick_d;
      cursor_q    <= cursor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    btn_q      <= btn_d;
    t_q        <= t_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    lo_ent_q   <= lo_ent_d;
    status_q   <= status_d;
    app_q      <= app_d;
    out_btn_q  <= out_btn_d;
    out_stat_q <= out_stat_d;
    out_app_q  <= out_app_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.buttons_out = out_btn_q;
  assign out_o.status      = out_stat_q;
  assign out_o.appended    = out_app_q;
  assign out_o.entry_count = out_cnt_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CW'(LOG_DEPTH)))
    else $error("entry count out of range");

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH || state_q == S_WAIT) |-> (lo_q <= hi_q))
    else $error("search bounds crossed");

  a_write_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr != '0) && (CW'(ram_waddr) == count_q))
    else $error("log write outside the append slot");

  a_append_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_o.appended) |-> (out_o.status == STAT_OK))
    else $error("appended item reports a drop");

  a_probe_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) |-> $past(ram_re) && (mid_q != '0))
    else $error("probe data used without a read");
`endif

endmodule

// File: dv/tb_timestamped_input_record_replay.sv
`timescale 1ns / 1ps
// testbench for timestamped_input_record_replay: directed, log-fill and random request items
// with a shadow log that predicts every result; depends on tirr_pkg, tirr_if and the rtl

module tb_timestamped_input_record_replay;
  import tirr_pkg::*;

  localparam int unsigned LogDepth = 4096;
  localparam longint unsigned MaxTick = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    op_e             op;
    logic [BtnW-1:0] btn;
    logic [TickW-1:0] tick;
    bit              drain;
  } req_t;

  typedef struct packed {
    logic [BtnW-1:0]   buttons;
    status_e           status;
    logic              appended;
    logic [CountW-1:0] count;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tirr_in_if  req ();
  tirr_out_if rsp ();

  timestamped_input_record_replay #(.LOG_DEPTH(LogDepth)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req),
    .out_o  (rsp)
  );

  always #1 clk_i = ~clk_i;

  // shadow copy of the log
  entry_t      shadow_log [LogDepth];
  int unsigned shadow_cnt;
  logic [BtnW-1:0] shadow_last;
  int unsigned shadow_cursor;

  req_t    request_backlog [$];
  result_t expected_results [$];
  int unsigned sent_cnt;
  int unsigned results_got;
  int unsigned err_cnt;

  function automatic int unsigned log_lookup(logic [TickW-1:0] q);
    int unsigned lo, hi, mid;
    lo = 0;
    if (shadow_log[0].tick > q) return 0;
    hi = shadow_cnt - 1;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (shadow_log[mid].tick <= q) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic void log_predict(op_e op, logic [BtnW-1:0] btn, logic [TickW-1:0] t);
    result_t r;
    int unsigned idx;
    r.status = STAT_OK;
    r.appended = 1'b0;
    case (op)
      OP_RECORD, OP_FORCE: begin
        if (op == OP_FORCE || btn != shadow_last) begin
          // full wins over out-of-order
          if (shadow_cnt >= LogDepth) begin
            r.status = STAT_FULL;
          end else if (t < shadow_log[shadow_cnt-1].tick) begin
            r.status = STAT_ORDER;
          end else begin
            shadow_log[shadow_cnt] = '{tick: t, buttons: btn};
            shadow_cnt++;
            shadow_last = btn;
            r.appended = 1'b1;
          end
        end
      end
      OP_PLAY: shadow_cursor = log_lookup(t);
      default: begin
        idx = log_lookup(t);
        shadow_cnt = idx + 1;
        shadow_last = shadow_log[idx].buttons;
        if (shadow_cursor > idx) shadow_cursor = idx;
      end
    endcase
    idx = log_lookup(t);
    r.buttons = shadow_log[idx].buttons;
    r.count = CountW'(shadow_cnt);
    expected_results.push_back(r);
  endfunction

  function automatic logic [TickW-1:0] rand48();
    return TickW'({$urandom, $urandom});
  endfunction

  function automatic void push_req(op_e op, logic [BtnW-1:0] btn, longint unsigned t, bit drain);
    req_t r;
    r.op = op;
    r.btn = btn;
    r.tick = TickW'(t);
    r.drain = drain;
    request_backlog.push_back(r);
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch at result %0d, %s: got 0x%0h expected 0x%0h", results_got, what, got,
             want);
    err_cnt++;
  endtask

  // driver: bursts of items with random gaps
  int unsigned gap_left, burst_left;
  always @(posedge clk_i or negedge rst_ni) begin
    req_t nxt;
    int unsigned acc_total;
    logic took;
    if (!rst_ni) begin
      req.valid <= 1'b0;
      sent_cnt <= 0;
      gap_left <= 0;
      burst_left <= 8;
    end else begin
      took = req.valid && req.ready;
      acc_total = sent_cnt;
      if (took) begin
        log_predict(op_e'(req.opcode), req.button_set, req.tick_time);
        acc_total++;
        sent_cnt <= acc_total;
      end
      if (!req.valid || took) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          req.valid <= 1'b0;
        end else if (request_backlog.size() == 0 ||
                     (request_backlog[0].drain && acc_total != results_got)) begin
          req.valid <= 1'b0;
        end else begin
          nxt = request_backlog.pop_front();
          req.valid <= 1'b1;
          req.opcode <= nxt.op;
          req.button_set <= nxt.btn;
          req.tick_time <= nxt.tick;
          if (burst_left <= 1) begin
            // now and then a long burst with no gaps at all
            burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 30);
            gap_left <= $urandom_range(0, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  int unsigned cyc_cnt, hold_left;
  logic rx_hold;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc_cnt <= 0;
      hold_left <= 0;
    end else begin
      cyc_cnt <= cyc_cnt + 1;
      if (cyc_cnt == 3000 || cyc_cnt == 150000) hold_left <= 400;
      else if (hold_left != 0) hold_left <= hold_left - 1;
    end
  end
  assign rx_hold = (hold_left != 0);

  // monitor and receiver stall pattern
  int unsigned rx_mode, mode_left;
  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    logic rdy;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      results_got <= 0;
      rx_mode <= 0;
      mode_left <= 50;
    end else begin
      if (rsp.valid && rsp.ready) begin
        results_got <= results_got + 1;
        if (expected_results.size() == 0) begin
          flag_mismatch("result with no request pending", rsp.buttons_out, 0);
        end else begin
          e = expected_results.pop_front();
          if (rsp.buttons_out !== e.buttons)
            flag_mismatch("buttons_out", rsp.buttons_out, e.buttons);
          if (rsp.status !== e.status) flag_mismatch("status", rsp.status, e.status);
          if (rsp.appended !== e.appended) flag_mismatch("appended", rsp.appended, e.appended);
          if (rsp.entry_count !== e.count)
            flag_mismatch("entry_count", rsp.entry_count, e.count);
        end
      end
      if (mode_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
      rsp.ready <= rdy && !rx_hold;
    end
  end

  initial begin
    longint unsigned gen_tick, t;
    logic [BtnW-1:0] gen_btn, prev;
    int unsigned k, r;

    req.valid = 1'b0;
    req.opcode = OP_RECORD;
    req.button_set = '0;
    req.tick_time = '0;
    rsp.ready = 1'b0;
    err_cnt = 0;
    shadow_log[0] = '{tick: '0, buttons: '0};
    shadow_cnt = 1;
    shadow_last = '0;
    shadow_cursor = 0;

    // directed: empty log, unchanged record, duplicates, order, truncate, extremes
    push_req(OP_PLAY,   8'h00, 0, 0);
    push_req(OP_PLAY,   8'h00, MaxTick, 0);
    push_req(OP_RECORD, 8'h00, 5, 0);
    push_req(OP_RECORD, 8'hFF, 10, 0);
    push_req(OP_RECORD, 8'hFF, 12, 0);
    push_req(OP_FORCE,  8'hFF, 12, 0);
    push_req(OP_FORCE,  8'h5A, 12, 0);
    push_req(OP_PLAY,   8'h00, 12, 0);
    push_req(OP_PLAY,   8'h00, 11, 0);
    push_req(OP_PLAY,   8'h00, 9, 0);
    push_req(OP_RECORD, 8'hA5, 3, 0);
    push_req(OP_RECORD, 8'h5A, 3, 0);
    push_req(OP_FORCE,  8'h01, 1, 0);
    push_req(OP_TRUNC,  8'h00, 11, 0);
    push_req(OP_RECORD, 8'hFF, 20, 0);
    push_req(OP_RECORD, 8'h80, MaxTick, 0);
    push_req(OP_FORCE,  8'h00, MaxTick, 0);
    push_req(OP_PLAY,   8'hFF, MaxTick, 0);
    push_req(OP_TRUNC,  8'hFF, 0, 0);
    push_req(OP_TRUNC,  8'h00, MaxTick, 0);
    push_req(OP_RECORD, 8'h00, 0, 0);
    push_req(OP_FORCE,  8'h00, 0, 0);
    push_req(OP_PLAY,   8'h00, 0, 0);

    // fill the log to its depth, then hit the full cases
    push_req(OP_TRUNC, 8'($urandom), 0, 1);
    prev = '0;
    t = 1000;
    for (int unsigned i = 1; i < LogDepth; i++) begin
      prev = prev ^ 8'($urandom_range(1, 255));
      t += $urandom_range(0, 3);
      push_req(OP_RECORD, prev, t, 0);
    end
    push_req(OP_RECORD, ~prev, t + 5, 0);
    push_req(OP_FORCE,  prev, t + 5, 0);
    push_req(OP_FORCE,  8'hFF, 0, 0);
    for (int unsigned i = 0; i < 8; i++) push_req(OP_PLAY, 8'($urandom), rand48() % (t + 10), 0);
    gen_tick = 1000 + rand48() % (t - 1000);
    push_req(OP_TRUNC, 8'($urandom), gen_tick, 0);

    // random: mostly in-order appends mixed with queries, truncates and noise
    gen_btn = 8'($urandom);
    for (int unsigned i = 0; i < 1000; i++) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 19);
      if (r < 55) begin
        if (k == 0) begin
          t = rand48();
          if (t > gen_tick) gen_tick = t;
        end else if (k == 1) begin
          t = (gen_tick == 0) ? 0 : rand48() % gen_tick;
        end else begin
          t = gen_tick + $urandom_range(0, 4);
          if (t > MaxTick) t = MaxTick;
          gen_tick = t;
        end
        if ($urandom_range(0, 9) < 6) gen_btn = 8'($urandom);
        push_req((r < 35) ? OP_RECORD : OP_FORCE, gen_btn, t, (i == 0) || (k == 2 && r < 3));
      end else if (r < 85) begin
        t = (k < 14) ? rand48() % (gen_tick + 8) : rand48();
        push_req(OP_PLAY, 8'($urandom), t, i == 0);
      end else begin
        gen_tick = rand48() % (gen_tick + 1);
        push_req(OP_TRUNC, 8'($urandom), gen_tick, i == 0);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_backlog.size() != 0 || req.valid || sent_cnt != results_got)
      @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
